// File: rtl/vc_pkg.sv
// ---------------------------------------------------------------------------
// vc_pkg: shared definitions for the varint codec
// Command and result codes, encoding thresholds and the job word that the
// front end hands to the back end through the job queue.
// ---------------------------------------------------------------------------
package vc_pkg;

    // Default job queue depth (entries between front and back end)
    localparam int unsigned Q_DEPTH_DEF = 2;

    // Command codes on the input channel
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Result kinds on the output channel
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    // Encode thresholds
    localparam logic [63:0] ONE_BYTE_LIMIT   = 64'd241;
    localparam logic [63:0] TWO_BYTE_LIMIT   = 64'd2288;
    localparam logic [63:0] THREE_BYTE_LIMIT = 64'd67824;

    // Offsets subtracted before packing the short forms
    localparam logic [11:0] TWO_BYTE_BASE   = 12'd240;
    localparam logic [16:0] THREE_BYTE_BASE = 17'd2288;

    // Lead byte codes
    localparam logic [7:0] LEAD_TWO_MIN   = 8'd241;
    localparam logic [7:0] LEAD_TWO_MAX   = 8'd248;
    localparam logic [7:0] LEAD_THREE     = 8'd249;
    localparam logic [7:0] LEAD_LONG_BASE = 8'd247;  // lead = base + payload bytes
    localparam logic [7:0] LEAD_LEN_OFS   = 8'd246;  // length = lead - offset

    // One queued job: an encoded byte string (lead byte in the top byte,
    // left aligned) or a decoded value in the low 64 bits.
    typedef struct packed {
        logic        kind;
        logic [3:0]  len;
        logic [71:0] data;
    } t_job;

endpackage

// File: rtl/vc_if.sv
// ---------------------------------------------------------------------------
// vc_if: valid/ready channels of the varint codec
// Input channel carries commands, output channel carries result items.
// ---------------------------------------------------------------------------
interface vc_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] value_in;
    logic [7:0]  byte_in;

    modport source (output valid, output cmd, output value_in, output byte_in,
                    input ready);
    modport sink   (input valid, input cmd, input value_in, input byte_in,
                    output ready);
endinterface

interface vc_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  byte_out;
    logic [63:0] value_out;
    logic [3:0]  length;
    logic        last;

    modport source (output valid, output kind, output byte_out, output value_out,
                    output length, output last, input ready);
    modport sink   (input valid, input kind, input byte_out, input value_out,
                    input length, input last, output ready);
endinterface

// File: rtl/vc_queue.sv
// ---------------------------------------------------------------------------
// vc_queue: job queue between front and back end
// Small register FIFO of job words; first-word-fall-through read.
// ---------------------------------------------------------------------------
module vc_queue #(
    parameter int unsigned DEPTH = vc_pkg::Q_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vc_pkg::t_job  i_job,
    input  logic          i_pop,
    output vc_pkg::t_job  o_job,
    output logic          o_full,
    output logic          o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    vc_pkg::t_job  r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    // pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // never written when full, never read when empty
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job queue read while empty");

endmodule

// File: rtl/vc_front.sv
// ---------------------------------------------------------------------------
// vc_front: command front end
// Accepts input transactions, packs encodes into byte strings and runs the
// decode state; pushes one job per item that yields results.
// ---------------------------------------------------------------------------
module vc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vc_in_if.sink         i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output vc_pkg::t_job  o_job
);

    // decode state
    logic [7:0]  r_lead, n_lead;
    logic [3:0]  r_seen, n_seen;
    logic [3:0]  r_exp,  n_exp;
    logic [63:0] r_acc,  n_acc;

    logic         accept;
    vc_pkg::t_job enc_job;
    logic [11:0]  d2;
    logic [16:0]  d3;
    logic [3:0]   nb;
    logic [63:0]  v;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign v          = i_in.value_in;

    // encode: byte count and left-aligned byte string
    always_comb begin
        d2 = v[11:0] - vc_pkg::TWO_BYTE_BASE;
        d3 = v[16:0] - vc_pkg::THREE_BYTE_BASE;
        if (v[63:56] != '0)      nb = 4'd8;
        else if (v[55:48] != '0) nb = 4'd7;
        else if (v[47:40] != '0) nb = 4'd6;
        else if (v[39:32] != '0) nb = 4'd5;
        else if (v[31:24] != '0) nb = 4'd4;
        else                     nb = 4'd3;

        enc_job.kind = vc_pkg::KIND_BYTE;
        if (v < vc_pkg::ONE_BYTE_LIMIT) begin
            enc_job.len  = 4'd1;
            enc_job.data = {v[7:0], 64'd0};
        end else if (v < vc_pkg::TWO_BYTE_LIMIT) begin
            enc_job.len  = 4'd2;
            enc_job.data = {vc_pkg::LEAD_TWO_MIN + {5'd0, d2[10:8]}, d2[7:0], 56'd0};
        end else if (v < vc_pkg::THREE_BYTE_LIMIT) begin
            enc_job.len  = 4'd3;
            enc_job.data = {vc_pkg::LEAD_THREE, d3[15:0], 48'd0};
        end else begin
            enc_job.len = nb + 4'd1;
            case (nb)
                4'd3:    enc_job.data = {vc_pkg::LEAD_LONG_BASE + 8'd3, v[23:0], 40'd0};
                4'd4:    enc_job.data = {vc_pkg::LEAD_LONG_BASE + 8'd4, v[31:0], 32'd0};
                4'd5:    enc_job.data = {vc_pkg::LEAD_LONG_BASE + 8'd5, v[39:0], 24'd0};
                4'd6:    enc_job.data = {vc_pkg::LEAD_LONG_BASE + 8'd6, v[47:0], 16'd0};
                4'd7:    enc_job.data = {vc_pkg::LEAD_LONG_BASE + 8'd7, v[55:0], 8'd0};
                default: enc_job.data = {vc_pkg::LEAD_LONG_BASE + 8'd8, v};
            endcase
        end
    end

    // decode: state update and completed value
    logic [63:0] acc_shift;
    logic [3:0]  seen_inc;
    logic [7:0]  len_from_lead;
    logic [3:0]  lead_low;
    logic [11:0] sum2;
    logic [16:0] sum3;
    logic [63:0] dec_value;

    always_comb begin
        acc_shift     = {r_acc[55:0], i_in.byte_in};
        seen_inc      = r_seen + 4'd1;
        len_from_lead = i_in.byte_in - vc_pkg::LEAD_LEN_OFS;
        lead_low      = r_lead[3:0] - 4'd1;
        sum2          = vc_pkg::TWO_BYTE_BASE + {1'b0, lead_low[2:0], acc_shift[7:0]};
        sum3          = vc_pkg::THREE_BYTE_BASE + {1'b0, acc_shift[15:0]};
        if (r_lead <= vc_pkg::LEAD_TWO_MAX) begin
            dec_value = {52'd0, sum2};
        end else if (r_lead == vc_pkg::LEAD_THREE) begin
            dec_value = {47'd0, sum3};
        end else begin
            dec_value = acc_shift;
        end
    end

    always_comb begin
        n_lead = r_lead;
        n_seen = r_seen;
        n_exp  = r_exp;
        n_acc  = r_acc;
        o_push = 1'b0;
        o_job  = enc_job;
        if (accept) begin
            if (i_in.cmd == vc_pkg::CMD_ENCODE) begin
                o_push = 1'b1;
            end else if (r_seen == '0) begin
                if (i_in.byte_in < vc_pkg::LEAD_TWO_MIN) begin
                    // single-byte encoding completes at once
                    o_push = 1'b1;
                    o_job  = '{kind: vc_pkg::KIND_VALUE, len: 4'd1,
                               data: {64'd0, i_in.byte_in}};
                end else begin
                    n_lead = i_in.byte_in;
                    n_exp  = (i_in.byte_in <= vc_pkg::LEAD_TWO_MAX) ?
                             4'd2 : len_from_lead[3:0];
                    n_seen = 4'd1;
                    n_acc  = '0;
                end
            end else if (seen_inc < r_exp) begin
                n_acc  = acc_shift;
                n_seen = seen_inc;
            end else begin
                // final byte: emit value, back to no decode in progress
                o_push = 1'b1;
                o_job  = '{kind: vc_pkg::KIND_VALUE, len: r_exp,
                           data: {8'd0, dec_value}};
                n_lead = '0;
                n_seen = '0;
                n_exp  = '0;
                n_acc  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
            r_seen <= '0;
            r_exp  <= '0;
            r_acc  <= '0;
        end else begin
            r_lead <= n_lead;
            r_seen <= n_seen;
            r_exp  <= n_exp;
            r_acc  <= n_acc;
        end
    end

endmodule

// File: rtl/vc_back.sv
// ---------------------------------------------------------------------------
// vc_back: result back end
// Takes jobs from the queue; while o_out takes results, sends one per cycle
// into the output register: a byte string bytewise, a decoded value at once.
// ---------------------------------------------------------------------------
module vc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vc_pkg::t_job  i_job,
    input  logic          i_q_empty,
    output logic          o_pop,
    vc_out_if.source      o_out
);

    // job in progress
    logic        r_busy, n_busy;
    logic [71:0] r_rem,  n_rem;
    logic [3:0]  r_left, n_left;
    logic [3:0]  r_len,  n_len;

    // output register
    logic        r_valid, n_valid;
    logic        r_kind,  n_kind;
    logic [7:0]  r_byte,  n_byte;
    logic [63:0] r_value, n_value;
    logic [3:0]  r_olen,  n_olen;
    logic        r_last,  n_last;

    logic can_load;

    assign can_load = !r_valid || o_out.ready;

    // next result selection
    always_comb begin
        n_busy  = r_busy;
        n_rem   = r_rem;
        n_left  = r_left;
        n_len   = r_len;
        n_valid = r_valid && !o_out.ready;
        n_kind  = r_kind;
        n_byte  = r_byte;
        n_value = r_value;
        n_olen  = r_olen;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (can_load) begin
            if (r_busy) begin
                // following byte of the string in progress
                n_valid = 1'b1;
                n_kind  = vc_pkg::KIND_BYTE;
                n_byte  = r_rem[71:64];
                n_value = '0;
                n_olen  = r_len;
                n_last  = (r_left == 4'd1);
                n_rem   = {r_rem[63:0], 8'd0};
                n_left  = r_left - 4'd1;
                n_busy  = (r_left != 4'd1);
            end else if (!i_q_empty) begin
                // first result straight from the queue head
                o_pop   = 1'b1;
                n_valid = 1'b1;
                n_kind  = i_job.kind;
                n_olen  = i_job.len;
                if (i_job.kind == vc_pkg::KIND_VALUE) begin
                    // a decoded value is a single result whatever its length
                    n_byte  = '0;
                    n_value = i_job.data[63:0];
                    n_last  = 1'b1;
                    n_busy  = 1'b0;
                end else begin
                    n_byte  = i_job.data[71:64];
                    n_value = '0;
                    n_last  = (i_job.len == 4'd1);
                    n_busy  = (i_job.len != 4'd1);
                end
                n_rem  = {i_job.data[63:0], 8'd0};
                n_left = i_job.len - 4'd1;
                n_len  = i_job.len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_left  <= n_left;
        r_len   <= n_len;
        r_kind  <= n_kind;
        r_byte  <= n_byte;
        r_value <= n_value;
        r_olen  <= n_olen;
        r_last  <= n_last;
    end

    assign o_out.valid     = r_valid;
    assign o_out.kind      = r_kind;
    assign o_out.byte_out  = r_byte;
    assign o_out.value_out = r_value;
    assign o_out.length    = r_olen;
    assign o_out.last      = r_last;

    // bytes still to send always fewer than the string length
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != 4'd0 && r_left < r_len))
        else $error("byte counter out of range");

    // a decoded value is always the only result of its item
    a_value_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == vc_pkg::KIND_VALUE) |-> r_last)
        else $error("decoded value without last");

    // no new job is taken before the string in progress is finished
    a_hold_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_left != 4'd1) |-> !o_pop)
        else $error("job popped while a string is in progress");

endmodule

// File: rtl/varint_codec.sv
// ---------------------------------------------------------------------------
// varint_codec: variable-length integer encoder and decoder
// Channel i_in takes commands: encode value_in (cmd 0) or decode byte_in
// (cmd 1). Channel o_out returns results: encoded bytes (kind 0), lead byte
// first, or a decoded value (kind 1) with its byte length; last marks the
// final result of a command.
// An encode yields 1 to 9 byte results, one per cycle while o_out is ready;
// the back end's output register sends all bytes of one string before it
// takes the next job. Decode bytes are accepted back to back; only the
// byte that completes an encoding yields a result. An accepted command
// passes through the job queue and the output register before its result.
// The front end accepts while the job queue (Q_DEPTH entries) has room, so
// commands keep flowing while results wait. When o_out stalls, the held
// result stays put, the queue fills and then i_in.ready drops.
// Reset (i_rst_n low, synchronous) empties the queue and output register
// and clears any partial decode.
// ---------------------------------------------------------------------------
module varint_codec #(
    parameter int unsigned Q_DEPTH = vc_pkg::Q_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vc_in_if.sink     i_in,
    vc_out_if.source  o_out
);

    logic         push;
    logic         pop;
    logic         q_full;
    logic         q_empty;
    vc_pkg::t_job job_in;
    vc_pkg::t_job job_out;

    vc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (job_in)
    );

    vc_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    vc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (job_out),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
